@@ rtl/u8vs_pkg.sv @@
// ----------------------------------------------------------------------------
// u8vs_pkg
// Constants and decode helpers for the UTF-8 validate/sanitize unit.
// ----------------------------------------------------------------------------
package u8vs_pkg;

    localparam logic [7:0]  REPL_RESET   = 8'h3F;

    localparam logic [7:0]  MASK_ASCII   = 8'h80;
    localparam logic [7:0]  MASK_LEAD2   = 8'hE0;
    localparam logic [7:0]  CODE_LEAD2   = 8'hC0;
    localparam logic [7:0]  MASK_LEAD3   = 8'hF0;
    localparam logic [7:0]  CODE_LEAD3   = 8'hE0;
    localparam logic [7:0]  MASK_LEAD4   = 8'hF8;
    localparam logic [7:0]  CODE_LEAD4   = 8'hF0;
    localparam logic [7:0]  MASK_CONT    = 8'hC0;
    localparam logic [7:0]  CODE_CONT    = 8'h80;

    localparam logic [20:0] MIN_CP2      = 21'h00080;
    localparam logic [20:0] MIN_CP3      = 21'h00800;
    localparam logic [20:0] MIN_CP4      = 21'h10000;
    localparam logic [20:0] SURR_LO      = 21'h0D800;
    localparam logic [20:0] SURR_HI      = 21'h0DFFF;
    localparam logic [20:0] MAX_CP       = 21'h10FFFF;

    localparam logic [2:0]  LEN_NONE     = 3'd0;
    localparam logic [2:0]  LEN_ONE      = 3'd1;
    localparam logic [2:0]  LEN_TWO      = 3'd2;
    localparam logic [2:0]  LEN_THREE    = 3'd3;
    localparam logic [2:0]  LEN_FOUR     = 3'd4;

    typedef logic [7:0] byte_t;

    // Sequence length announced by a lead byte; LEN_NONE for an invalid lead.
    function automatic logic [2:0] lead_len(input byte_t b);
        logic [2:0] len;
        begin
            if ((b & MASK_ASCII) == 8'h00)
                len = LEN_ONE;
            else if ((b & MASK_LEAD2) == CODE_LEAD2)
                len = LEN_TWO;
            else if ((b & MASK_LEAD3) == CODE_LEAD3)
                len = LEN_THREE;
            else if ((b & MASK_LEAD4) == CODE_LEAD4)
                len = LEN_FOUR;
            else
                len = LEN_NONE;
            return len;
        end
    endfunction

    function automatic logic is_cont(input byte_t b);
        return (b & MASK_CONT) == CODE_CONT;
    endfunction

    // Check a complete sequence of n bytes.
    function automatic logic seq_ok(input byte_t b0, input byte_t b1,
                                    input byte_t b2, input byte_t b3,
                                    input logic [2:0] n);
        logic [20:0] cp2;
        logic [20:0] cp3;
        logic [20:0] cp4;
        logic        ok;
        begin
            cp2 = {10'd0, b0[4:0], b1[5:0]};
            cp3 = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            cp4 = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            case (n)
                LEN_ONE:   ok = 1'b1;
                LEN_TWO:   ok = is_cont(b1) && (cp2 >= MIN_CP2);
                LEN_THREE: ok = is_cont(b1) && is_cont(b2) && (cp3 >= MIN_CP3)
                                && !((cp3 >= SURR_LO) && (cp3 <= SURR_HI));
                LEN_FOUR:  ok = is_cont(b1) && is_cont(b2) && is_cont(b3)
                                && (cp4 >= MIN_CP4) && (cp4 <= MAX_CP);
                default:   ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

endpackage

@@ rtl/utf8_validate_sanitize_unit.sv @@
// An accepted byte is registered in the input holding register, then processed into the
// result register that drives the outputs.
// Throughput: one result per cycle while the output is not stalled; an item that gives
// n results holds the input while the single result register shifts out its run.
// Buffered bytes give no result and pass at one per cycle when no run stalls the input.
// Reset: sequence state and string flag clear, replacement byte returns to 0x3F.
// ----------------------------------------------------------------------------
// utf8_validate_sanitize_unit
// UTF-8 validator/sanitizer: buffers a multi-byte sequence, then emits it
// unchanged or as one replacement byte per consumed byte.
// ----------------------------------------------------------------------------
module utf8_validate_sanitize_unit
    import u8vs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       was_replaced,
    output logic       run_last,
    output logic       string_end,
    output logic       string_valid
);

    logic [7:0] repl_reg;

    logic       inq_valid_reg;
    logic       inq_valid_next;
    byte_t      inq_data_reg;
    logic       inq_fin_reg;

    byte_t      seq_store_reg [3];
    byte_t      seq_store_next [3];
    logic [2:0] seq_expected_reg;
    logic [2:0] seq_expected_next;
    logic [2:0] seq_filled_reg;
    logic [2:0] seq_filled_next;
    logic       string_bad_reg;
    logic       string_bad_next;

    byte_t      grp_bytes_reg [4];
    byte_t      grp_bytes_next [4];
    logic [2:0] grp_left_reg;
    logic [2:0] grp_left_next;
    logic       grp_rep_reg;
    logic       grp_rep_next;
    logic       grp_fin_reg;
    logic       grp_fin_next;
    logic       grp_ok_reg;
    logic       grp_ok_next;

    logic       in_take;
    logic       out_take;
    logic       grp_free;
    logic       proc;
    byte_t      cand [4];
    logic [2:0] held;
    logic [2:0] n_bytes;
    logic [2:0] lead;
    logic [2:0] cnt;
    logic       rep;

    assign out_take = out_valid && !out_stall;
    assign grp_free = (grp_left_reg == 3'd0) || ((grp_left_reg == 3'd1) && !out_stall);
    assign proc     = inq_valid_reg && grp_free;
    assign in_stall = inq_valid_reg && !grp_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        inq_valid_next = inq_valid_reg;
        if (in_take)
            inq_valid_next = 1'b1;
        else if (proc)
            inq_valid_next = 1'b0;
    end

    // Candidate sequence: held bytes, then the new byte.
    assign held    = (seq_expected_reg == LEN_NONE) ? 3'd0 : seq_filled_reg;
    assign n_bytes = held + 3'd1;
    assign lead    = lead_len(inq_data_reg);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            cand[k] = (3'(k) < held) ? seq_store_reg[k] : inq_data_reg;
        cand[3] = inq_data_reg;
    end

    always_comb
    begin
        seq_store_next    = seq_store_reg;
        seq_expected_next = seq_expected_reg;
        seq_filled_next   = seq_filled_reg;
        string_bad_next   = string_bad_reg;
        cnt               = 3'd0;
        rep               = 1'b0;
        if (proc)
        begin
            if (seq_expected_reg == LEN_NONE)
            begin
                if (lead == LEN_NONE)
                begin
                    cnt = 3'd1;
                    rep = 1'b1;
                end
                else if (lead == LEN_ONE)
                begin
                    cnt = 3'd1;
                end
                else if (inq_fin_reg)
                begin
                    cnt = 3'd1;
                    rep = 1'b1;
                end
                else
                begin
                    seq_store_next[0] = inq_data_reg;
                    seq_expected_next = lead;
                    seq_filled_next   = 3'd1;
                end
            end
            else if (n_bytes >= seq_expected_reg)
            begin
                cnt               = n_bytes;
                rep               = !seq_ok(cand[0], cand[1], cand[2], cand[3], n_bytes);
                seq_expected_next = LEN_NONE;
                seq_filled_next   = 3'd0;
            end
            else if (inq_fin_reg)
            begin
                // truncated by end of string: replace everything held and the final byte
                cnt               = n_bytes;
                rep               = 1'b1;
                seq_expected_next = LEN_NONE;
                seq_filled_next   = 3'd0;
            end
            else
            begin
                seq_store_next[held[1:0]] = inq_data_reg;
                seq_filled_next           = n_bytes;
            end
            if (rep)
                string_bad_next = 1'b1;
            if (inq_fin_reg)
            begin
                seq_expected_next = LEN_NONE;
                seq_filled_next   = 3'd0;
                string_bad_next   = 1'b0;
            end
        end
    end

    // Result run: load on processing, shift one byte out per transaction.
    always_comb
    begin
        grp_bytes_next = grp_bytes_reg;
        grp_left_next  = grp_left_reg;
        grp_rep_next   = grp_rep_reg;
        grp_fin_next   = grp_fin_reg;
        grp_ok_next    = grp_ok_reg;
        if (proc)
        begin
            grp_bytes_next = cand;
            grp_left_next  = cnt;
            grp_rep_next   = rep;
            grp_fin_next   = inq_fin_reg;
            grp_ok_next    = !(string_bad_reg || rep);
        end
        else if (out_take)
        begin
            for (int k = 0; k < 3; k++)
                grp_bytes_next[k] = grp_bytes_reg[k + 1];
            grp_left_next = grp_left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg         <= REPL_RESET;
            inq_valid_reg    <= 1'b0;
            seq_expected_reg <= LEN_NONE;
            seq_filled_reg   <= 3'd0;
            string_bad_reg   <= 1'b0;
            grp_left_reg     <= 3'd0;
        end
        else
        begin
            if (cfg_write)
                repl_reg <= cfg_data;
            inq_valid_reg    <= inq_valid_next;
            seq_expected_reg <= seq_expected_next;
            seq_filled_reg   <= seq_filled_next;
            string_bad_reg   <= string_bad_next;
            grp_left_reg     <= grp_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            inq_data_reg <= data_byte;
            inq_fin_reg  <= final_byte;
        end
        seq_store_reg <= seq_store_next;
        grp_bytes_reg <= grp_bytes_next;
        grp_rep_reg   <= grp_rep_next;
        grp_fin_reg   <= grp_fin_next;
        grp_ok_reg    <= grp_ok_next;
    end

    assign out_valid    = (grp_left_reg != 3'd0);
    assign out_byte     = grp_rep_reg ? repl_reg : grp_bytes_reg[0];
    assign was_replaced = grp_rep_reg;
    assign run_last     = (grp_left_reg == 3'd1);
    assign string_end   = run_last && grp_fin_reg;
    assign string_valid = string_end && grp_ok_reg;

endmodule

@@ rtl/u8vs_checker.sv @@
// ----------------------------------------------------------------------------
// u8vs_checker
// Port-level checks for the UTF-8 validate/sanitize unit.
// ----------------------------------------------------------------------------
module u8vs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] data_byte,
    input logic       final_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       was_replaced,
    input logic       run_last,
    input logic       string_end,
    input logic       string_valid
);

    // hold a stalled input transaction
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(final_byte))
        else $error("stalled input changed");

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(was_replaced) && $stable(run_last))
        else $error("stalled result changed");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string end not on last result of run");

    a_valid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_valid |-> string_end && !was_replaced)
        else $error("string reported valid on a replaced or non-final result");

    // a replaced run continues as replaced until its last result
    a_rep_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && was_replaced && !run_last
            |=> out_valid && was_replaced)
        else $error("replaced run broken");

endmodule

bind utf8_validate_sanitize_unit u8vs_checker u_u8vs_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 validate/sanitize unit. A short table of
// hand-picked bytes hits lead extremes, overlong, surrogate, out-of-range,
// broken and truncated sequences. Random strings follow under several
// replacement bytes. The strings are mostly well-formed code points with
// random content, mixed with noise. Each output transaction is compared
// field by field against an in-bench predictor, while the input bursts and
// the output stalls vary.
// ----------------------------------------------------------------------------
module tb_top;
    import u8vs_pkg::*;

    typedef struct packed {
        byte_t ob;
        logic  rep;
        logic  last;
        logic  send;
        logic  svalid;
    } san_res_t;

    typedef struct packed {
        byte_t d;
        logic  fin;
        logic  typed;
        byte_t t_out;
        logic  t_rep;
        logic  t_valid;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       cfg_write    = 1'b0;
    logic [7:0] cfg_data     = 8'h00;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte    = 8'h00;
    logic       final_byte   = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       run_last;
    logic       string_end;
    logic       string_valid;

    // predictor state
    byte_t      seq_hold [3];
    logic [2:0] seq_len   = LEN_NONE;
    logic [2:0] seq_cnt   = 3'd0;
    logic       str_bad   = 1'b0;
    byte_t      repl_byte = REPL_RESET;

    san_res_t   pending_out [$];
    byte_t      str_buf [$];

    int err_count  = 0;
    int n_bytes    = 0;
    int n_strings  = 0;
    int n_results  = 0;
    int n_replaced = 0;
    int n_settings = 0;
    int burst_left = 0;
    int stall_tick = 0;
    int stall_mode = 0;

    // Directed rows; typed expectations only for single-result bytes.
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 8'h00,      1'b0, 1'b0},  // ASCII low extreme
        '{8'h7F, 1'b0, 1'b1, 8'h7F,      1'b0, 1'b0},  // ASCII high extreme
        '{8'hC2, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},  // smallest 2-byte value
        '{8'h80, 1'b1, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b1, REPL_RESET, 1'b1, 1'b0},  // stray continuation
        '{8'hFF, 1'b0, 1'b1, REPL_RESET, 1'b1, 1'b0},  // 11111xxx lead
        '{8'hC1, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},  // overlong 2-byte
        '{8'hBF, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'hED, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},  // surrogate
        '{8'hA0, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'hF0, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},  // overlong 4-byte
        '{8'h8F, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'hF4, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},  // above U+10FFFF
        '{8'h90, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'hE2, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},  // bad continuation
        '{8'h41, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'hE2, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0},  // cut by end of string
        '{8'h82, 1'b1, 1'b0, 8'h00,      1'b0, 1'b0},
        '{8'hC3, 1'b1, 1'b1, REPL_RESET, 1'b1, 1'b0},  // lead as final byte
        '{8'hF8, 1'b1, 1'b1, REPL_RESET, 1'b1, 1'b0}
    };

    // Append one expected result to the scoreboard.
    function automatic void expect_result(input san_res_t r);
        pending_out = {pending_out, r};
    endfunction

    // Append one byte to the string under construction.
    function automatic void buf_add(input byte_t b);
        str_buf = {str_buf, b};
    endfunction

    utf8_validate_sanitize_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .was_replaced (was_replaced),
        .run_last     (run_last),
        .string_end   (string_end),
        .string_valid (string_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int utf8_lead_class(input byte_t b);
        int len;
        casez (b)
            8'b0???????: len = 1;
            8'b110?????: len = 2;
            8'b1110????: len = 3;
            8'b11110???: len = 4;
            default:     len = 0;
        endcase
        return len;
    endfunction

    function automatic logic utf8_group_legal(input logic [3:0][7:0] g, input int n);
        logic [20:0] cp;
        logic        ok;
        ok = 1'b1;
        for (int k = 1; k < n; k++)
            if (g[k][7:6] != 2'b10)
                ok = 1'b0;
        case (n)
            2:
            begin
                cp = {10'd0, g[0][4:0], g[1][5:0]};
                ok = ok && (cp >= MIN_CP2);
            end
            3:
            begin
                cp = {5'd0, g[0][3:0], g[1][5:0], g[2][5:0]};
                ok = ok && (cp >= MIN_CP3) && !(cp >= SURR_LO && cp <= SURR_HI);
            end
            4:
            begin
                cp = {g[0][2:0], g[1][5:0], g[2][5:0], g[3][5:0]};
                ok = ok && (cp >= MIN_CP4) && (cp <= MAX_CP);
            end
            default: ok = ok;
        endcase
        return ok;
    endfunction

    // Advance the predictor by one accepted byte; queue its results when asked.
    function automatic void predict_sanitized(input byte_t d, input logic fin,
                                              input bit emit);
        logic [3:0][7:0] grp;
        int              cnt;
        int              held;
        int              len;
        logic            rep;
        logic            last;
        san_res_t        r;
        grp  = '0;
        cnt  = 0;
        rep  = 1'b0;
        if (seq_len == LEN_NONE)
        begin
            len    = utf8_lead_class(d);
            grp[0] = d;
            if (len == 0)
            begin
                cnt = 1;
                rep = 1'b1;
            end
            else if (len == 1)
                cnt = 1;
            else if (fin)
            begin
                cnt = 1;
                rep = 1'b1;
            end
            else
            begin
                seq_hold[0] = d;
                seq_len     = 3'(len);
                seq_cnt     = 3'd1;
            end
        end
        else
        begin
            held = int'(seq_cnt);
            for (int k = 0; k < held; k++)
                grp[k] = seq_hold[k];
            grp[held] = d;
            if (held + 1 >= int'(seq_len))
            begin
                cnt     = held + 1;
                rep     = !utf8_group_legal(grp, held + 1);
                seq_len = LEN_NONE;
                seq_cnt = 3'd0;
            end
            else if (fin)
            begin
                cnt = held + 1;
                rep = 1'b1;
            end
            else
            begin
                seq_hold[held] = d;
                seq_cnt        = 3'(held + 1);
            end
        end
        if (rep)
            str_bad = 1'b1;
        for (int k = 0; k < cnt; k++)
        begin
            last     = (k + 1 == cnt);
            r.ob     = rep ? repl_byte : grp[k];
            r.rep    = rep;
            r.last   = last;
            r.send   = last && fin;
            r.svalid = last && fin && !str_bad;
            if (emit)
                expect_result(r);
        end
        if (fin)
        begin
            seq_len = LEN_NONE;
            seq_cnt = 3'd0;
            str_bad = 1'b0;
        end
    endfunction

    // Hold the byte until the unit takes it; sender works in bursts.
    task automatic send_item(input byte_t d, input logic fin, input bit emit);
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(8, 14);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        in_valid   <= 1'b1;
        data_byte  <= d;
        final_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_sanitized(d, fin, emit);
        burst_left--;
        n_bytes++;
    endtask

    task automatic drain(input int settle);
        in_valid  <= 1'b0;
        burst_left = 0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_repl(input byte_t v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        repl_byte  = v;
        n_settings++;
    endtask

    function automatic void encode_cp(input logic [20:0] c, input int n);
        case (n)
            1: buf_add({1'b0, c[6:0]});
            2:
            begin
                buf_add({3'b110, c[10:6]});
                buf_add({2'b10, c[5:0]});
            end
            3:
            begin
                buf_add({4'b1110, c[15:12]});
                buf_add({2'b10, c[11:6]});
                buf_add({2'b10, c[5:0]});
            end
            default:
            begin
                buf_add({5'b11110, c[20:18]});
                buf_add({2'b10, c[17:12]});
                buf_add({2'b10, c[11:6]});
                buf_add({2'b10, c[5:0]});
            end
        endcase
    endfunction

    // Append one code point, mostly well-formed, sometimes broken.
    function automatic void add_code_point();
        int          pick;
        int          n;
        int          pos;
        logic [20:0] cp;
        byte_t       b;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            encode_cp(21'($urandom_range(0, 127)), 1);
        else if (pick < 40)
            encode_cp(21'($urandom_range(32'h80, 32'h7FF)), 2);
        else if (pick < 55)
        begin
            cp = 21'($urandom_range(32'h800, 32'hFFFF));
            if (cp >= SURR_LO && cp <= SURR_HI)
                cp = cp ^ 21'h02000;
            encode_cp(cp, 3);
        end
        else if (pick < 65)
            encode_cp(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
        else if (pick < 72)
        begin
            case ($urandom_range(0, 7))
                0: encode_cp(21'h00080, 2);
                1: encode_cp(21'h007FF, 2);
                2: encode_cp(21'h00800, 3);
                3: encode_cp(21'h0D7FF, 3);
                4: encode_cp(21'h0E000, 3);
                5: encode_cp(21'h0FFFF, 3);
                6: encode_cp(21'h10000, 4);
                default: encode_cp(21'h10FFFF, 4);
            endcase
        end
        else if (pick < 78)
        begin
            // overlong forms
            n = $urandom_range(2, 4);
            if (n == 2)
                cp = 21'($urandom_range(0, 32'h7F));
            else if (n == 3)
                cp = 21'($urandom_range(0, 32'h7FF));
            else
                cp = 21'($urandom_range(0, 32'hFFFF));
            encode_cp(cp, n);
        end
        else if (pick < 82)
            encode_cp(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
        else if (pick < 86)
            encode_cp(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
        else if (pick < 92)
        begin
            // break one continuation byte
            n = $urandom_range(2, 4);
            encode_cp(21'($urandom_range(0, 32'h1FFFFF)), n);
            pos = str_buf.size() - n + $urandom_range(1, n - 1);
            b   = byte_t'($urandom_range(0, 255));
            if (b[7:6] == 2'b10)
                b[6] = 1'b1;
            str_buf[pos] = b;
        end
        else if (pick < 96)
            buf_add($urandom_range(0, 1) ? byte_t'($urandom_range(8'h80, 8'hBF))
                                         : byte_t'($urandom_range(8'hF8, 8'hFF)));
        else
            buf_add(byte_t'($urandom_range(0, 255)));
    endfunction

    task automatic send_random_strings(input int target);
        int first;
        int ntok;
        int tok_start;
        int len;
        first = n_bytes;
        while (n_bytes - first < target)
        begin
            str_buf.delete();
            tok_start = 0;
            ntok      = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 7);
            for (int t = 0; t < ntok; t++)
            begin
                tok_start = str_buf.size();
                add_code_point();
            end
            // sometimes cut the last sequence short
            len = str_buf.size() - tok_start;
            if (len > 1 && $urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, len - 1)) void'(str_buf.pop_back());
            for (int i = 0; i < str_buf.size(); i++)
                send_item(str_buf[i], i == str_buf.size() - 1, 1'b1);
            n_strings++;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Receiver: stall pattern follows one of four modes, redrawn at random.
    always @(posedge clk)
    begin
        stall_tick++;
        if (stall_tick % 50 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_tick % 8) < 5);
        endcase
    end

    always @(posedge clk)
    begin : check_out
        san_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_out.size() == 0)
                report_mismatch("transaction with nothing expected, out_byte", out_byte, 0);
            else
            begin
                want = pending_out.pop_front();
                n_results++;
                if (want.rep)
                    n_replaced++;
                if (out_byte !== want.ob)
                    report_mismatch("out_byte", out_byte, want.ob);
                if (was_replaced !== want.rep)
                    report_mismatch("was_replaced", was_replaced, want.rep);
                if (run_last !== want.last)
                    report_mismatch("run_last", run_last, want.last);
                if (string_end !== want.send)
                    report_mismatch("string_end", string_end, want.send);
                if (string_valid !== want.svalid)
                    report_mismatch("string_valid", string_valid, want.svalid);
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the reset replacement byte
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tab[i].typed)
                expect_result(san_res_t'{dir_tab[i].t_out, dir_tab[i].t_rep, 1'b1,
                                         dir_tab[i].fin, dir_tab[i].t_valid});
            send_item(dir_tab[i].d, dir_tab[i].fin, !dir_tab[i].typed);
        end
        n_strings += 4;
        send_random_strings(85);

        drain(6);
        write_repl(8'h00);
        send_random_strings(80);

        drain(6);
        write_repl(8'hFF);
        send_random_strings(80);

        drain(6);
        write_repl(byte_t'($urandom_range(1, 254)));
        send_random_strings(80);

        drain(12);
        $display("Covered %0d bytes in %0d strings under %0d replacement settings",
                 n_bytes, n_strings, n_settings + 1);
        $display("Checked %0d output transactions, %0d of them replacements, %0d errors",
                 n_results, n_replaced, err_count);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("ERROR: time limit reached with %0d transactions outstanding",
                 pending_out.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
